[rtl/core/grid_bfs_next_step_router_core_defines.svh]
// assertion macros for the grid bfs router checker
// expects clk and arst_n in the scope where a macro is used
`ifndef GRID_BFS_NEXT_STEP_ROUTER_CORE_DEFINES_SVH
`define GRID_BFS_NEXT_STEP_ROUTER_CORE_DEFINES_SVH

// same-cycle implication
`define GBFS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gbfs same-cycle check failed");

// next-cycle implication
`define GBFS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gbfs next-cycle check failed");

`endif

[rtl/core/gbfs_pkg.sv]
// shared codes, constants and types of the grid bfs router
// no dependencies
package gbfs_pkg;
	localparam int MAX_DIM_DEF = 64;

	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_SEARCH = 2'd1;
	localparam logic [1:0] FUNC_QUERY  = 2'd2;

	localparam logic [1:0] KIND_OPEN    = 2'd0;
	localparam logic [1:0] KIND_WALL    = 2'd1;
	localparam logic [1:0] KIND_BLOCKED = 2'd2;
	localparam logic [1:0] KIND_EXIT    = 2'd3;

	localparam logic [3:0] ANS_WALL    = 4'd0;
	localparam logic [3:0] ANS_BLOCKED = 4'd1;
	localparam logic [3:0] ANS_EXIT    = 4'd2;
	localparam logic [3:0] ANS_UNREACH = 4'd3;
	localparam logic [3:0] ANS_LEFT    = 4'd4;
	localparam logic [3:0] ANS_UP      = 4'd7;
	localparam logic [3:0] ANS_OOR     = 4'd8;

	localparam logic REPLY_SEARCH = 1'b0;
	localparam logic REPLY_QUERY  = 1'b1;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam logic [6:0] DIM_RESET = 7'd64;

	typedef struct packed {
		logic kind_we;
		logic visit_we;
	} gbfs_wr_t;
endpackage

[rtl/core/grid_bfs_next_step_router_core.sv]
// grid bfs router top: control sequencer around the cell and queue memories
// depends on gbfs_pkg, gbfs_grid_mem, gbfs_queue
//
// channel  | handshake         | payload
// command  | start / busy      | func, row, col, kind
// result   | done (strobe)     | reply_type, answer, exit_found
// config   | cfg_we            | cfg_idx, cfg_wdata
//
// load: written from idle, with no result. query: answered from idle if out of range, else
// read on the single cell read port (self then four neighbors, one read issued per cycle).
// search: a pass clearing the reached marks of all MAX_DIM*MAX_DIM cells, then per
// reached cell a queue pop, dequeue, four neighbor reads and one drain step.
// after reset a clearing pass over all MAX_DIM*MAX_DIM cells runs with busy high.
// results last one cycle on done; the receiver cannot stall.
module grid_bfs_next_step_router_core #(
	parameter int MAX_DIM = gbfs_pkg::MAX_DIM_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] func,
	input  logic [5:0] row,
	input  logic [5:0] col,
	input  logic [1:0] kind,
	output logic       done,
	output logic       reply_type,
	output logic [3:0] answer,
	output logic       exit_found,
	input  logic       cfg_we,
	input  logic       cfg_idx,
	input  logic [6:0] cfg_wdata
);
	import gbfs_pkg::*;

	localparam int RW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CELLS = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(CELLS);
	localparam int QW    = AW + 2 * RW;

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_POP   = 3'd3;
	localparam logic [2:0] ST_DEQ   = 3'd4;
	localparam logic [2:0] ST_SCAN  = 3'd5;
	localparam logic [2:0] ST_QUERY = 3'd6;

	localparam logic [2:0] SL_SELF  = 3'd0;
	localparam logic [2:0] SL_LEFT  = 3'd1;
	localparam logic [2:0] SL_DOWN  = 3'd2;
	localparam logic [2:0] SL_RIGHT = 3'd3;
	localparam logic [2:0] SL_UP    = 3'd4;

	logic [2:0]    state_q;
	logic [6:0]    rows_q, cols_q;
	logic [5:0]    exit_row_q, exit_col_q;
	logic          exit_present_q;
	logic [AW:0]   head_q, tail_q;
	logic [AW-1:0] clr_addr_q;
	logic          clr_srch_q;
	logic [RW-1:0] cr_q, cc_q;
	logic [AW-1:0] cd_q;
	logic [2:0]    slot_q;
	logic          vld_s1, inr_s1;
	logic [2:0]    slot_s1;
	logic [AW-1:0] addr_s1;
	logic [RW-1:0] nr_s1, nc_s1;
	logic          best_vld_q;
	logic [2:0]    best_slot_q;
	logic [AW:0]   best_d_q;

	logic [6:0]    rows_eff, cols_eff;
	logic          in_grid, exit_ok, accept;
	logic [AW-1:0] in_idx, exit_idx;
	logic [RW-1:0] nr, nc;
	logic          inr;
	logic [AW-1:0] issue_addr;
	logic [1:0]    kind_rd;
	logic          reached_rd, passable;
	logic [AW-1:0] dist_rd;
	logic [AW:0]   d_ext;
	logic          take, upd;
	logic [2:0]    fin_slot;
	logic          fin_vld;
	logic [AW-1:0] next_dist;
	gbfs_wr_t      wr;
	logic [AW-1:0] visit_waddr;
	logic [AW:0]   visit_wdata;
	logic          q_we;
	logic [AW-1:0] q_waddr;
	logic [QW-1:0] q_wdata, q_rdata;

	assign rows_eff = (int'(rows_q) > MAX_DIM) ? 7'(MAX_DIM) : rows_q;
	assign cols_eff = (int'(cols_q) > MAX_DIM) ? 7'(MAX_DIM) : cols_q;
	assign in_grid  = (int'(row) < int'(rows_eff)) && (int'(col) < int'(cols_eff));
	assign in_idx   = AW'(int'(row) * MAX_DIM + int'(col));
	assign exit_ok  = exit_present_q && (int'(exit_row_q) < int'(rows_eff))
		&& (int'(exit_col_q) < int'(cols_eff));
	assign exit_idx = AW'(int'(exit_row_q) * MAX_DIM + int'(exit_col_q));
	assign accept   = start && !busy;
	assign busy     = (state_q != ST_IDLE);

	// neighbor address for the slot being issued
	always_comb begin
		nr  = cr_q;
		nc  = cc_q;
		inr = 1'b1;
		case (slot_q)
			SL_SELF: begin
				inr = 1'b1;
			end
			SL_LEFT: begin
				nc  = cc_q - RW'(1);
				inr = (cc_q != '0);
			end
			SL_DOWN: begin
				nr  = cr_q + RW'(1);
				inr = (int'(cr_q) + 1 < int'(rows_eff));
			end
			SL_RIGHT: begin
				nc  = cc_q + RW'(1);
				inr = (int'(cc_q) + 1 < int'(cols_eff));
			end
			SL_UP: begin
				nr  = cr_q - RW'(1);
				inr = (cr_q != '0);
			end
			default: begin
				inr = 1'b0;
			end
		endcase
		issue_addr = inr ? AW'(int'(nr) * MAX_DIM + int'(nc)) : '0;
	end

	assign passable  = (kind_rd == KIND_OPEN) || (kind_rd == KIND_EXIT);
	assign d_ext     = reached_rd ? {1'b0, dist_rd} : '1;
	assign next_dist = cd_q + AW'(1);
	assign take      = (state_q == ST_SCAN) && vld_s1 && inr_s1 && !reached_rd && passable;
	assign upd       = (state_q == ST_QUERY) && vld_s1 && (slot_s1 != SL_SELF) && inr_s1
		&& passable && (!best_vld_q || (d_ext < best_d_q));
	assign fin_vld   = best_vld_q || upd;
	assign fin_slot  = upd ? slot_s1 : best_slot_q;

	// memory write ports
	always_comb begin
		wr.kind_we  = (state_q == ST_IDLE) && accept && (func == FUNC_LOAD) && in_grid;
		wr.visit_we = 1'b0;
		visit_waddr = addr_s1;
		visit_wdata = {1'b1, next_dist};
		q_we        = 1'b0;
		q_waddr     = tail_q[AW-1:0];
		q_wdata     = {next_dist, nr_s1, nc_s1};
		case (state_q)
			ST_CLR: begin
				wr.visit_we = 1'b1;
				visit_waddr = clr_addr_q;
				visit_wdata = '0;
			end
			ST_START: begin
				wr.visit_we = exit_ok;
				visit_waddr = exit_idx;
				visit_wdata = {1'b1, AW'(0)};
				q_we        = exit_ok;
				q_waddr     = '0;
				q_wdata     = {AW'(0), RW'(exit_row_q), RW'(exit_col_q)};
			end
			ST_SCAN: begin
				wr.visit_we = take;
				q_we        = take;
			end
			default: begin
				wr.visit_we = 1'b0;
			end
		endcase
	end

	gbfs_grid_mem #(.AW(AW)) u_grid (
		.clk         (clk),
		.wr          (wr),
		.kind_waddr  (in_idx),
		.kind_wdata  (kind),
		.visit_waddr (visit_waddr),
		.visit_wdata (visit_wdata),
		.rd_addr     (issue_addr),
		.kind_rd     (kind_rd),
		.reached_rd  (reached_rd),
		.dist_rd     (dist_rd)
	);

	gbfs_queue #(.AW(AW), .W(QW)) u_queue (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (head_q[AW-1:0]),
		.rdata (q_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLR;
			rows_q         <= DIM_RESET;
			cols_q         <= DIM_RESET;
			exit_row_q     <= '0;
			exit_col_q     <= '0;
			exit_present_q <= 1'b0;
			head_q         <= '0;
			tail_q         <= '0;
			clr_addr_q     <= '0;
			clr_srch_q     <= 1'b0;
			slot_q         <= SL_SELF;
			vld_s1         <= 1'b0;
			best_vld_q     <= 1'b0;
			done           <= 1'b0;
			reply_type     <= REPLY_SEARCH;
			answer         <= ANS_WALL;
			exit_found     <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				if (cfg_idx == REG_ROWS) begin
					rows_q <= cfg_wdata;
				end else begin
					cols_q <= cfg_wdata;
				end
			end
			case (state_q)
				ST_CLR: begin
					if (int'(clr_addr_q) == CELLS - 1) begin
						clr_addr_q <= '0;
						state_q    <= clr_srch_q ? ST_START : ST_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (func)
							FUNC_LOAD: begin
								if (in_grid && kind == KIND_EXIT) begin
									exit_row_q     <= row;
									exit_col_q     <= col;
									exit_present_q <= 1'b1;
								end
							end
							FUNC_SEARCH: begin
								clr_srch_q <= 1'b1;
								state_q    <= ST_CLR;
							end
							FUNC_QUERY: begin
								if (in_grid) begin
									cr_q       <= RW'(row);
									cc_q       <= RW'(col);
									slot_q     <= SL_SELF;
									vld_s1     <= 1'b0;
									best_vld_q <= 1'b0;
									state_q    <= ST_QUERY;
								end else begin
									done       <= 1'b1;
									reply_type <= REPLY_QUERY;
									answer     <= ANS_OOR;
									exit_found <= 1'b0;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_START: begin
					head_q  <= '0;
					tail_q  <= exit_ok ? (AW+1)'(1) : '0;
					state_q <= ST_POP;
				end
				ST_POP: begin
					if (head_q == tail_q) begin
						done       <= 1'b1;
						reply_type <= REPLY_SEARCH;
						answer     <= ANS_WALL;
						exit_found <= exit_present_q;
						state_q    <= ST_IDLE;
					end else begin
						head_q  <= head_q + (AW+1)'(1);
						state_q <= ST_DEQ;
					end
				end
				ST_DEQ: begin
					cd_q    <= q_rdata[QW-1:2*RW];
					cr_q    <= q_rdata[2*RW-1:RW];
					cc_q    <= q_rdata[RW-1:0];
					slot_q  <= SL_LEFT;
					vld_s1  <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN, ST_QUERY: begin
					// issue one cell read per cycle, check the previous one
					vld_s1  <= (slot_q <= SL_UP);
					slot_s1 <= slot_q;
					inr_s1  <= inr;
					addr_s1 <= issue_addr;
					nr_s1   <= nr;
					nc_s1   <= nc;
					if (slot_q <= SL_UP) begin
						slot_q <= slot_q + 3'd1;
					end
					if (take) begin
						tail_q <= tail_q + (AW+1)'(1);
					end
					if (upd) begin
						best_vld_q  <= 1'b1;
						best_slot_q <= slot_s1;
						best_d_q    <= d_ext;
					end
					if (state_q == ST_SCAN && vld_s1 && slot_s1 == SL_UP) begin
						state_q <= ST_POP;
					end
					if (state_q == ST_QUERY && vld_s1) begin
						if (slot_s1 == SL_SELF) begin
							if (kind_rd != KIND_OPEN || !reached_rd) begin
								done       <= 1'b1;
								reply_type <= REPLY_QUERY;
								exit_found <= 1'b0;
								state_q    <= ST_IDLE;
								case (kind_rd)
									KIND_WALL:    answer <= ANS_WALL;
									KIND_BLOCKED: answer <= ANS_BLOCKED;
									KIND_EXIT:    answer <= ANS_EXIT;
									default:      answer <= ANS_UNREACH;
								endcase
							end
						end else if (slot_s1 == SL_UP) begin
							done       <= 1'b1;
							reply_type <= REPLY_QUERY;
							exit_found <= 1'b0;
							answer     <= fin_vld ? (ANS_LEFT + 4'(fin_slot - SL_LEFT))
								: ANS_UNREACH;
							state_q    <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

[rtl/core/gbfs_grid_mem.sv]
// cell memories: kind and visit word (reached mark plus distance)
// depends on gbfs_pkg
module gbfs_grid_mem #(
	parameter int AW = 12
) (
	input  logic             clk,
	input  gbfs_pkg::gbfs_wr_t wr,
	input  logic [AW-1:0]    kind_waddr,
	input  logic [1:0]       kind_wdata,
	input  logic [AW-1:0]    visit_waddr,
	input  logic [AW:0]      visit_wdata,
	input  logic [AW-1:0]    rd_addr,
	output logic [1:0]       kind_rd,
	output logic             reached_rd,
	output logic [AW-1:0]    dist_rd
);
	import gbfs_pkg::*;

	localparam int DEPTH = 1 << AW;

	logic [1:0]  kind_mem [DEPTH];
	logic [AW:0] visit_mem [DEPTH];
	logic [AW:0] visit_q;

	always_ff @(posedge clk) begin
		if (wr.kind_we) begin
			kind_mem[kind_waddr] <= kind_wdata;
		end
		kind_rd <= kind_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.visit_we) begin
			visit_mem[visit_waddr] <= visit_wdata;
		end
		visit_q <= visit_mem[rd_addr];
	end

	assign reached_rd = visit_q[AW];
	assign dist_rd    = visit_q[AW-1:0];
endmodule

[rtl/core/gbfs_queue.sv]
// search queue storage, one write and one registered read per cycle
// depends on gbfs_pkg
module gbfs_queue #(
	parameter int AW = 12,
	parameter int W  = 24
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	import gbfs_pkg::*;

	logic [W-1:0] mem [1 << AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/core/gbfs_checker.sv]
// port-level checks on the grid bfs router, bound to the top level
// depends on gbfs_pkg and grid_bfs_next_step_router_core_defines.svh
`include "grid_bfs_next_step_router_core_defines.svh"

module gbfs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] func,
	input logic       done,
	input logic       reply_type,
	input logic [3:0] answer,
	input logic       exit_found
);
	import gbfs_pkg::*;

	// a search always sweeps the marks first
	`GBFS_ASSERT_NXT(a_search_busy, start && !busy && func == FUNC_SEARCH, busy && !done)
	// a load finishes at once with no transfer
	`GBFS_ASSERT_NXT(a_load_quiet, start && !busy && func == FUNC_LOAD, !busy && !done)
	`GBFS_ASSERT_IMP(a_search_reply, done && reply_type == REPLY_SEARCH, answer == ANS_WALL)
	`GBFS_ASSERT_IMP(a_query_reply, done && reply_type == REPLY_QUERY,
		!exit_found && answer <= ANS_OOR)
	// every transfer lands as the block turns idle
	`GBFS_ASSERT_IMP(a_done_idle, done, !busy)
endmodule

bind grid_bfs_next_step_router_core gbfs_checker u_gbfs_checker (.*);

[tb/sv/grid_bfs_next_step_router_core_test.sv]
// testbench for grid_bfs_next_step_router_core: command driver, result monitor, bfs predictor
// depends on gbfs_pkg and the router core rtl
module grid_bfs_next_step_router_core_test;
	import gbfs_pkg::*;

	localparam int DIM = 64;
	localparam int CELLS = DIM * DIM;
	localparam int STALL_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic [1:0] func;
		logic [5:0] row;
		logic [5:0] col;
		logic [1:0] kind;
	} cmd_t;

	typedef struct {
		logic       reply_type;
		logic [3:0] answer;
		logic       exit_found;
	} reply_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] func;
	logic [5:0] row;
	logic [5:0] col;
	logic [1:0] kind;
	logic       done;
	logic       reply_type;
	logic [3:0] answer;
	logic       exit_found;
	logic       cfg_we;
	logic       cfg_idx;
	logic [6:0] cfg_wdata;

	grid_bfs_next_step_router_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .row(row), .col(col), .kind(kind),
		.done(done), .reply_type(reply_type), .answer(answer), .exit_found(exit_found),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	// grid model
	logic [1:0] grid_kind [CELLS];
	bit         grid_reached [CELLS];
	int         grid_dist [CELLS];
	bit         cell_loaded [CELLS];
	logic [6:0] rows_reg;
	logic [6:0] cols_reg;
	int         exit_r;
	int         exit_c;
	bit         have_exit;

	int dir_row [4] = '{0, 1, 0, -1};
	int dir_col [4] = '{-1, 0, 1, 0};

	cmd_t   pending_cmds [$];
	reply_t expected_replies [$];
	int     idle_pct;
	int     err_count;
	int     stall_cycles;
	cmd_t   held_cmd;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int eff_dim(logic [6:0] v);
		return (v > DIM) ? DIM : int'(v);
	endfunction

	function automatic bit is_passable(int idx);
		return grid_kind[idx] == KIND_OPEN || grid_kind[idx] == KIND_EXIT;
	endfunction

	function automatic void expect_reply(reply_t rep);
		expected_replies.insert(expected_replies.size(), rep);
	endfunction

	function automatic void flood_from_exit();
		int nrows, ncols, cur, r, c, nr, nc, n;
		int frontier [$];
		nrows = eff_dim(rows_reg);
		ncols = eff_dim(cols_reg);
		foreach (grid_reached[i]) grid_reached[i] = 0;
		if (!have_exit || exit_r >= nrows || exit_c >= ncols)
			return;
		cur = exit_r * DIM + exit_c;
		grid_reached[cur] = 1;
		grid_dist[cur] = 0;
		frontier.insert(frontier.size(), cur);
		while (frontier.size() > 0) begin
			cur = frontier.pop_front();
			r = cur / DIM;
			c = cur % DIM;
			for (int i = 0; i < 4; i++) begin
				nr = r + dir_row[i];
				nc = c + dir_col[i];
				if (nr < 0 || nc < 0 || nr >= nrows || nc >= ncols)
					continue;
				n = nr * DIM + nc;
				if (grid_reached[n] || !is_passable(n))
					continue;
				grid_reached[n] = 1;
				grid_dist[n] = grid_dist[cur] + 1;
				frontier.insert(frontier.size(), n);
			end
		end
	endfunction

	function automatic logic [3:0] next_move(int r, int c);
		int nrows, ncols, idx, nr, nc, n, best;
		longint d, best_d;
		nrows = eff_dim(rows_reg);
		ncols = eff_dim(cols_reg);
		best = -1;
		best_d = 64'h7fff_ffff_ffff;
		if (r >= nrows || c >= ncols)
			return ANS_OOR;
		idx = r * DIM + c;
		if (grid_kind[idx] == KIND_WALL) return ANS_WALL;
		if (grid_kind[idx] == KIND_BLOCKED) return ANS_BLOCKED;
		if (grid_kind[idx] == KIND_EXIT) return ANS_EXIT;
		if (!grid_reached[idx]) return ANS_UNREACH;
		for (int i = 0; i < 4; i++) begin
			nr = r + dir_row[i];
			nc = c + dir_col[i];
			if (nr < 0 || nc < 0 || nr >= nrows || nc >= ncols)
				continue;
			n = nr * DIM + nc;
			if (!is_passable(n))
				continue;
			// unreached passable neighbor counts as infinitely far
			d = grid_reached[n] ? grid_dist[n] : 64'h0000_ffff_ffff;
			if (best < 0 || d < best_d) begin
				best = i;
				best_d = d;
			end
		end
		if (best < 0)
			return ANS_UNREACH;
		return ANS_LEFT + 4'(best);
	endfunction

	function automatic void apply_cmd(cmd_t cmd);
		reply_t rep;
		int nrows, ncols;
		nrows = eff_dim(rows_reg);
		ncols = eff_dim(cols_reg);
		case (cmd.func)
			FUNC_LOAD: begin
				if (cmd.row < nrows && cmd.col < ncols) begin
					grid_kind[cmd.row * DIM + cmd.col] = cmd.kind;
					if (cmd.kind == KIND_EXIT) begin
						exit_r = cmd.row;
						exit_c = cmd.col;
						have_exit = 1;
					end
				end
			end
			FUNC_SEARCH: begin
				flood_from_exit();
				rep.reply_type = REPLY_SEARCH;
				rep.answer = ANS_WALL;
				rep.exit_found = have_exit;
				expect_reply(rep);
			end
			FUNC_QUERY: begin
				rep.reply_type = REPLY_QUERY;
				rep.answer = next_move(cmd.row, cmd.col);
				rep.exit_found = 1'b0;
				expect_reply(rep);
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		err_count++;
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				apply_cmd(held_cmd);
			end
			if (start && busy !== 1'b0) begin
				// transfer still pending, keep the item on the ports
			end else if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
				held_cmd = pending_cmds.pop_front();
				start <= 1'b1;
				func <= held_cmd.func;
				row <= held_cmd.row;
				col <= held_cmd.col;
				kind <= held_cmd.kind;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		reply_t want;
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (done === 1'b1) begin
				if (expected_replies.size() == 0) begin
					report_mismatch("unexpected reply, answer", answer, -1);
				end else begin
					want = expected_replies.pop_front();
					if (reply_type !== want.reply_type)
						report_mismatch("reply_type", reply_type, want.reply_type);
					if (answer !== want.answer)
						report_mismatch("answer", answer, want.answer);
					if (exit_found !== want.exit_found)
						report_mismatch("exit_found", exit_found, want.exit_found);
				end
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	task automatic push_cmd(logic [1:0] f, int r, int c, logic [1:0] k);
		cmd_t cmd;
		cmd.func = f;
		cmd.row = 6'(r);
		cmd.col = 6'(c);
		cmd.kind = k;
		if (f == FUNC_LOAD && r < eff_dim(rows_reg) && c < eff_dim(cols_reg))
			cell_loaded[r * DIM + c] = 1;
		pending_cmds.insert(pending_cmds.size(), cmd);
	endtask

	task automatic wait_quiet();
		do @(posedge clk);
		while (pending_cmds.size() != 0 || start || expected_replies.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_dims(logic [6:0] nrows, logic [6:0] ncols);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= REG_ROWS;
		cfg_wdata <= nrows;
		rows_reg = nrows;
		@(posedge clk);
		cfg_idx <= REG_COLS;
		cfg_wdata <= ncols;
		cols_reg = ncols;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// every in-range cell gets a kind before anything can read it
	task automatic load_unwritten(bit all_open);
		logic [1:0] k;
		int p;
		for (int r = 0; r < eff_dim(rows_reg); r++) begin
			for (int c = 0; c < eff_dim(cols_reg); c++) begin
				if (!cell_loaded[r * DIM + c]) begin
					p = $urandom_range(99);
					k = (all_open || p < 70) ? KIND_OPEN : (p < 90) ? KIND_WALL :
						(p < 97) ? KIND_BLOCKED : KIND_EXIT;
					push_cmd(FUNC_LOAD, r, c, k);
				end
			end
		end
	endtask

	task automatic random_cmds(int count, int search_pct);
		int p, r, c;
		logic [1:0] k;
		for (int n = 0; n < count; n++) begin
			p = $urandom_range(99);
			if ($urandom_range(9) == 0) begin
				r = $urandom_range(63);
				c = $urandom_range(63);
			end else begin
				r = $urandom_range((eff_dim(rows_reg) > 0) ? eff_dim(rows_reg) - 1 : 0);
				c = $urandom_range((eff_dim(cols_reg) > 0) ? eff_dim(cols_reg) - 1 : 0);
			end
			if (p < search_pct) begin
				push_cmd(FUNC_SEARCH, $urandom_range(63), $urandom_range(63),
					2'($urandom_range(3)));
			end else if (p < search_pct + 3) begin
				push_cmd(2'd3, r, c, 2'($urandom_range(3)));
			end else if (p < 52) begin
				p = $urandom_range(99);
				k = (p < 55) ? KIND_OPEN : (p < 80) ? KIND_WALL :
					(p < 90) ? KIND_BLOCKED : KIND_EXIT;
				push_cmd(FUNC_LOAD, r, c, k);
			end else begin
				push_cmd(FUNC_QUERY, r, c, 2'($urandom_range(3)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_LOAD;
		row = '0;
		col = '0;
		kind = KIND_OPEN;
		cfg_we = 1'b0;
		cfg_idx = REG_ROWS;
		cfg_wdata = '0;
		idle_pct = 19;
		err_count = 0;
		stall_cycles = 0;
		rows_reg = DIM_RESET;
		cols_reg = DIM_RESET;
		have_exit = 0;
		exit_r = 0;
		exit_c = 0;
		foreach (grid_kind[i]) begin
			grid_kind[i] = KIND_OPEN;
			grid_reached[i] = 0;
			grid_dist[i] = 0;
			cell_loaded[i] = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed part on a 4 by 5 grid
		write_dims(7'd4, 7'd5);
		load_unwritten(1'b1);
		push_cmd(FUNC_SEARCH, 0, 0, KIND_OPEN);
		push_cmd(FUNC_QUERY, 0, 0, KIND_OPEN);
		push_cmd(FUNC_QUERY, 63, 63, KIND_EXIT);
		push_cmd(FUNC_LOAD, 10, 0, KIND_WALL);
		push_cmd(FUNC_LOAD, 3, 4, KIND_EXIT);
		push_cmd(FUNC_LOAD, 1, 1, KIND_WALL);
		push_cmd(FUNC_LOAD, 2, 2, KIND_BLOCKED);
		push_cmd(FUNC_SEARCH, 0, 0, KIND_OPEN);
		push_cmd(FUNC_QUERY, 0, 0, KIND_OPEN);
		push_cmd(FUNC_QUERY, 1, 1, KIND_OPEN);
		push_cmd(FUNC_QUERY, 2, 2, KIND_OPEN);
		push_cmd(FUNC_QUERY, 3, 4, KIND_OPEN);
		push_cmd(FUNC_QUERY, 2, 4, KIND_OPEN);
		push_cmd(FUNC_QUERY, 3, 3, KIND_OPEN);
		push_cmd(FUNC_QUERY, 0, 4, KIND_OPEN);
		push_cmd(FUNC_LOAD, 3, 3, KIND_WALL);
		push_cmd(FUNC_LOAD, 1, 1, KIND_OPEN);
		push_cmd(FUNC_QUERY, 3, 2, KIND_OPEN);
		push_cmd(FUNC_QUERY, 1, 0, KIND_OPEN);
		push_cmd(2'd3, 0, 0, KIND_EXIT);
		// start cell reloaded as a wall, search still starts there
		push_cmd(FUNC_LOAD, 3, 4, KIND_WALL);
		push_cmd(FUNC_SEARCH, 63, 63, KIND_EXIT);
		push_cmd(FUNC_QUERY, 2, 4, KIND_OPEN);
		push_cmd(FUNC_QUERY, 0, 5, KIND_OPEN);
		wait_quiet();

		// random phases across grid sizes, extremes included
		write_dims(7'd8, 7'd8);
		load_unwritten(1'b0);
		random_cmds(120, 8);
		wait_quiet();
		write_dims(7'd1, 7'd1);
		load_unwritten(1'b0);
		random_cmds(60, 10);
		wait_quiet();
		idle_pct = 86;
		write_dims(7'd0, 7'd0);
		random_cmds(40, 10);
		wait_quiet();
		write_dims(7'd3, 7'd64);
		load_unwritten(1'b0);
		random_cmds(80, 8);
		wait_quiet();
		idle_pct = 0;
		// register values above the limit act as the limit
		write_dims(7'd127, 7'd2);
		load_unwritten(1'b0);
		random_cmds(80, 6);
		wait_quiet();
		write_dims(7'd2, 7'd100);
		random_cmds(60, 8);
		wait_quiet();
		// shrinking can leave the search start outside the grid
		write_dims(7'd6, 7'd7);
		load_unwritten(1'b0);
		random_cmds(60, 9);
		wait_quiet();
		write_dims(7'd64, 7'd2);
		random_cmds(50, 8);
		wait_quiet();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0 && expected_replies.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
